// ----- rtl/sof_pkg.sv -----
// sof_pkg: shared widths, register and verdict codes, controller/datapath structs
`timescale 1ns / 1ps

package sof_pkg;

  localparam int DW     = 24;       // sample and limit width
  localparam int SQW    = 2 * DW;   // width of one squared deviation
  localparam int CFG_IW = 2;        // configuration index width

  localparam logic [CFG_IW-1:0] REG_LOWER = 2'd0;
  localparam logic [CFG_IW-1:0] REG_UPPER = 2'd1;

  localparam logic signed [DW-1:0] LOWER_RST = 24'sd0;
  localparam logic signed [DW-1:0] UPPER_RST = 24'sd10000;

  localparam logic [1:0] VERD_PASS  = 2'd0;
  localparam logic [1:0] VERD_LIMIT = 2'd1;
  localparam logic [1:0] VERD_SIGMA = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // take sample, shift window when full
    logic sum;       // add one earlier entry to the sum
    logic div_init;  // start the mean divider
    logic div_step;  // one quotient bit
    logic mean;      // round and sign the quotient
    logic dev;       // deviation of one earlier entry
    logic xdev;      // deviation of the new sample
    logic sq;        // square the deviation
    logic acc;       // accumulate spread
    logic xmul;      // scale squared sample deviation by count, spread by nine
    logic wb;        // write back result, load output register
  } sof_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic zero_cnt;  // no earlier entries
    logic oor;       // sample outside limits
    logic last;      // index at the last earlier entry
    logic div_done;  // final divider step
  } sof_sts_t;

endpackage

// ----- rtl/sof_ctrl.sv -----
// sof_ctrl: sequencing state machine and output valid
`timescale 1ns / 1ps

module sof_ctrl
  import sof_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  sof_sts_t sts,
  output sof_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SUM   = 12'b0000_0000_0010,
    S_DINIT = 12'b0000_0000_0100,
    S_DIV   = 12'b0000_0000_1000,
    S_MEAN  = 12'b0000_0001_0000,
    S_DEV   = 12'b0000_0010_0000,
    S_SQ    = 12'b0000_0100_0000,
    S_ACC   = 12'b0000_1000_0000,
    S_XDEV  = 12'b0001_0000_0000,
    S_XSQ   = 12'b0010_0000_0000,
    S_XMUL  = 12'b0100_0000_0000,
    S_WB    = 12'b1000_0000_0000
  } sof_state_t;

  sof_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (sts.zero_cnt) begin
          state_nxt = S_WB;
        end else begin
          cmd.sum = 1'b1;
          if (sts.last) state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_MEAN;
      end
      S_MEAN: begin
        cmd.mean  = 1'b1;
        state_nxt = sts.oor ? S_WB : S_DEV;
      end
      S_DEV: begin
        cmd.dev   = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? S_XDEV : S_DEV;
      end
      S_XDEV: begin
        cmd.xdev  = 1'b1;
        state_nxt = S_XSQ;
      end
      S_XSQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_XMUL;
      end
      S_XMUL: begin
        cmd.xmul  = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd.wb        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/sof_dp.sv -----
// sof_dp: window, sum, bit-serial mean divider, spread and three-sigma test
`timescale 1ns / 1ps

module sof_dp
  import sof_pkg::*;
#(
  parameter int WINDOW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sof_cmd_t             cmd,
  output sof_sts_t             sts,
  input  logic signed [DW-1:0] in_sample,
  input  logic signed [DW-1:0] lower,
  input  logic signed [DW-1:0] upper,
  output logic signed [DW-1:0] out_filtered,
  output logic [1:0]           out_verdict
);

  localparam int IW   = $clog2(WINDOW);      // window index width
  localparam int CW   = $clog2(WINDOW + 1);  // fill count width
  localparam int SW   = DW + IW;             // signed sum width
  localparam int BW   = $clog2(SW);          // divider bit counter width
  localparam int SPW  = SQW + IW;            // spread width
  localparam int CMPW = SPW + 4;             // nine times spread

  logic signed [DW-1:0]  hist_r [WINDOW];
  logic [CW-1:0]         fill_r;
  logic [IW-1:0]         cnt_r;              // earlier entries of this transaction
  logic [IW-1:0]         idx_r;
  logic signed [DW-1:0]  x_r;
  logic                  oor_r;
  logic signed [SW-1:0]  sum_r;
  logic [SW-1:0]         quo_r;
  logic [IW-1:0]         rem_r;
  logic [BW-1:0]         bc_r;
  logic signed [DW-1:0]  mean_r;
  logic signed [DW:0]    e_r;
  logic [SQW-1:0]        sq_r;
  logic [SPW-1:0]        spread_r;
  logic [SPW-1:0]        lhs_r;
  logic [CMPW-1:0]       rhs_r;
  logic signed [DW-1:0]  filt_r;
  logic [1:0]            verd_r;

  logic [SW-1:0]         mag;
  logic [IW:0]           trial;
  logic                  ge;
  logic                  rnd;
  logic [SW-1:0]         q_rnd;
  logic signed [DW-1:0]  mean_nxt;
  logic signed [2*DW+1:0] prod;
  logic                  sigma;
  logic signed [DW-1:0]  res;
  logic [1:0]            verd;
  logic                  full;

  assign full = (fill_r == CW'(WINDOW));

  // magnitude of the sum for the unsigned divider
  assign mag   = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign trial = {rem_r, quo_r[SW-1]};
  assign ge    = (trial >= {1'b0, cnt_r});

  // round half away from zero: bump when twice the remainder reaches the count
  assign rnd      = ({rem_r, 1'b0} >= {1'b0, cnt_r});
  assign q_rnd    = quo_r + SW'(rnd);
  assign mean_nxt = sum_r[SW-1] ? DW'(-q_rnd) : DW'(q_rnd);

  assign prod = e_r * e_r;

  assign sigma = !(cnt_r == '0) && (spread_r != '0) && (CMPW'(lhs_r) > rhs_r);

  always_comb begin
    priority if (oor_r) begin
      res  = mean_r;
      verd = VERD_LIMIT;
    end else if (sigma) begin
      res  = mean_r;
      verd = VERD_SIGMA;
    end else begin
      res  = x_r;
      verd = VERD_PASS;
    end
  end

  assign sts.zero_cnt = (cnt_r == '0);
  assign sts.oor      = oor_r;
  assign sts.last     = (idx_r == IW'(cnt_r - 1'b1));
  assign sts.div_done = (bc_r == '0);

  assign out_filtered = filt_r;
  assign out_verdict  = verd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.wb) begin
      fill_r <= CW'(cnt_r) + 1'b1;
    end
  end

  // window storage: shift on load when full, write result back at the end
  always_ff @(posedge clk) begin
    if (cmd.load && full) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
    end
    if (cmd.wb) begin
      hist_r[cnt_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= in_sample;
      oor_r    <= (in_sample < lower) || (in_sample > upper);
      cnt_r    <= full ? IW'(WINDOW - 1) : IW'(fill_r);
      idx_r    <= '0;
      sum_r    <= '0;
      spread_r <= '0;
      mean_r   <= in_sample;  // lone value serves as its own mean
    end
    if (cmd.sum) begin
      sum_r <= sum_r + SW'(hist_r[idx_r]);
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.div_init) begin
      quo_r <= mag;
      rem_r <= '0;
      bc_r  <= BW'(SW - 1);
    end
    if (cmd.div_step) begin
      rem_r <= ge ? IW'(trial - {1'b0, cnt_r}) : IW'(trial);
      quo_r <= {quo_r[SW-2:0], ge};
      bc_r  <= bc_r - 1'b1;
    end
    if (cmd.mean) begin
      mean_r <= mean_nxt;
      idx_r  <= '0;
    end
    if (cmd.dev) begin
      e_r <= (DW+1)'(hist_r[idx_r]) - (DW+1)'(mean_r);
    end
    if (cmd.xdev) begin
      e_r <= (DW+1)'(x_r) - (DW+1)'(mean_r);
    end
    if (cmd.sq) begin
      sq_r <= prod[SQW-1:0];
    end
    if (cmd.acc) begin
      spread_r <= spread_r + SPW'(sq_r);
      idx_r    <= idx_r + 1'b1;
    end
    if (cmd.xmul) begin
      lhs_r <= SPW'(sq_r) * SPW'(cnt_r);
      rhs_r <= {spread_r, 3'b000} + CMPW'(spread_r);
    end
    if (cmd.wb) begin
      filt_r <= res;
      verd_r <= verd;
    end
  end

endmodule

// ----- rtl/sensor_outlier_filter.sv -----
// sensor_outlier_filter: top level with limit registers, controller and datapath
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_sample
//   out_     output     out_valid / out_stall out_filtered, out_verdict
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// one transaction at a time over m earlier entries (at most WINDOW-1), with
// SW = 24 + clog2(WINDOW); the mean divider yields one quotient bit a cycle for
// SW bits, and each entry takes a three-step square pass. a first sample after
// reset skips the mean and the spread; an out-of-limits one skips the spread.
// synchronous active-low reset empties the window and loads the limit defaults.
// a held result in the output register stalls only the final write-back step.
`timescale 1ns / 1ps

module sensor_outlier_filter
  import sof_pkg::*;
#(
  parameter int WINDOW = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [DW-1:0]   in_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [DW-1:0]   out_filtered,
  output logic [1:0]             out_verdict,
  input  logic                   cfg_we,
  input  logic [CFG_IW-1:0]      cfg_index,
  input  logic [DW-1:0]          cfg_data
);

  logic signed [DW-1:0] lower_r;
  logic signed [DW-1:0] upper_r;
  sof_cmd_t             cmd;
  sof_sts_t             sts;

  // unknown register indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RST;
      upper_r <= UPPER_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_LOWER) lower_r <= cfg_data;
      if (cfg_index == REG_UPPER) upper_r <= cfg_data;
    end
  end

  sof_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sof_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_sample    (in_sample),
    .lower        (lower_r),
    .upper        (upper_r),
    .out_filtered (out_filtered),
    .out_verdict  (out_verdict)
  );

`ifndef ASSERT_OFF
  // accepting a sample always starts a multi-cycle transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERD_PASS || out_verdict == VERD_LIMIT ||
                   out_verdict == VERD_SIGMA))
    else $error("undefined verdict code");

  // a passed sample must lie inside the limits
  a_pass_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VERD_PASS) |->
      (out_filtered >= lower_r && out_filtered <= upper_r))
    else $error("passed sample outside limits");
`endif

endmodule

// ----- bench/testbench.sv -----
// testbench: randomized check of sensor_outlier_filter against a windowed mean and sigma predictor
`timescale 1ns / 1ps

module testbench;
  import sof_pkg::*;

  localparam int WIN         = 5;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 218;
  localparam int PRINT_MAX   = 50;

  localparam logic [CFG_IW-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SPARE3 = 2'd3;

  localparam logic signed [DW-1:0] SAMPLE_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] SAMPLE_MAX = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    logic signed [DW-1:0] filtered;
    logic [1:0]           verdict;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [DW-1:0]  in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [DW-1:0]  out_filtered;
  logic [1:0]            out_verdict;
  logic                  cfg_we = 1'b0;
  logic [CFG_IW-1:0]     cfg_index = '0;
  logic [DW-1:0]         cfg_data = '0;

  logic signed [DW-1:0]  samples_to_send[$];
  reading_t              readings_due[$];

  // mirror of the filter window and limit registers
  logic signed [DW-1:0]  win_hist[WIN];
  int                    win_fill;
  logic signed [DW-1:0]  lim_lo;
  logic signed [DW-1:0]  lim_hi;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  logic signed [DW-1:0] dir_default[16] = '{-5, 100, 100, 100, 100, 100, 9000,
                                            1000, 1001, 1000, 1001, 6000,
                                            10000, 0, 10001, -1};
  logic signed [DW-1:0] dir_wide[6] = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                                        -1, -2};
  logic signed [DW-1:0] dir_crossed[3] = '{0, 50, -50};

  sensor_outlier_filter #(
    .WINDOW(WIN)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_filtered(out_filtered),
    .out_verdict (out_verdict),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic reading_t filter_sample(logic signed [DW-1:0] x);
    longint   sum;
    longint   cnt;
    longint   mag;
    longint   q;
    longint   mean_v;
    longint   dev;
    longint   spread;
    longint   e;
    int       n;
    int       i;
    reading_t r;
    if (win_fill >= WIN) begin
      for (i = 0; i < WIN - 1; i++) win_hist[i] = win_hist[i + 1];
      win_fill = WIN - 1;
    end
    win_hist[win_fill] = x;
    win_fill++;
    n = win_fill;
    cnt = n - 1;
    if (n < 2) begin
      mean_v = win_hist[0];
    end else begin
      sum = 0;
      for (i = 0; i < n - 1; i++) sum += win_hist[i];
      // round half away from zero
      mag = (sum < 0) ? -sum : sum;
      q = (2 * mag + cnt) / (2 * cnt);
      mean_v = (sum < 0) ? -q : q;
    end
    r.filtered = x;
    r.verdict = VERD_PASS;
    if (x < lim_lo || x > lim_hi) begin
      r.filtered = mean_v[DW-1:0];
      r.verdict = VERD_LIMIT;
    end else if (n >= 2) begin
      spread = 0;
      dev = longint'(x) - mean_v;
      for (i = 0; i < n - 1; i++) begin
        e = longint'(win_hist[i]) - mean_v;
        spread += e * e;
      end
      // squared form of the three-sigma test
      if (spread > 0 && dev * dev * cnt > 9 * spread) begin
        r.filtered = mean_v[DW-1:0];
        r.verdict = VERD_SIGMA;
      end
    end
    win_hist[n - 1] = r.filtered;
    return r;
  endfunction

  function automatic longint pick_base();
    longint               span;
    logic signed [DW-1:0] raw;
    raw = DW'($urandom);
    if (lim_lo > lim_hi) return longint'(raw);
    span = longint'(lim_hi) - longint'(lim_lo) + 1;
    return longint'(lim_lo) + longint'($urandom) % span;
  endfunction

  // mostly small noise around a level, some spikes, some arbitrary words
  function automatic logic signed [DW-1:0] gen_reading(longint base);
    longint               v;
    int                   pick;
    logic signed [DW-1:0] raw;
    pick = $urandom_range(99);
    raw = DW'($urandom);
    if (pick < 62) v = base + longint'($urandom_range(40)) - 20;
    else if (pick < 76) begin
      if ($urandom_range(1)) v = base + longint'($urandom_range(6000, 150));
      else v = base - longint'($urandom_range(6000, 150));
    end else if (pick < 90) v = pick_base();
    else v = longint'(raw);
    return v[DW-1:0];
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < PRINT_MAX) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [DW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LOWER) lim_lo = value;
    else if (idx == REG_UPPER) lim_hi = value;
  endtask

  task automatic set_limits(logic signed [DW-1:0] lo, logic signed [DW-1:0] hi);
    write_reg(REG_LOWER, lo);
    write_reg(REG_UPPER, hi);
    // spare indexes must leave both limits alone
    write_reg($urandom_range(1) ? REG_SPARE2 : REG_SPARE3, DW'($urandom));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || readings_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // driver: hold a stalled transaction, otherwise present the next sample or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) readings_due.push_back(filter_sample(in_sample));
      if (!in_valid || !in_stall) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_sample <= samples_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction filtered %0d verdict %0d",
                                    out_filtered, out_verdict));
        end else begin
          want = readings_due.pop_front();
          if (out_filtered !== want.filtered)
            report_mismatch($sformatf("filtered %0d, want %0d", out_filtered, want.filtered));
          if (out_verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d, want %0d", out_verdict, want.verdict));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (samples_to_send.size() == 0 && !in_valid && readings_due.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    longint               base;
    longint               t;
    int                   phase;
    int                   k;
    foreach (win_hist[i]) win_hist[i] = '0;
    win_fill = 0;
    lim_lo = LOWER_RST;
    lim_hi = UPPER_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limits: lone value, zero spread, sigma outlier, limit edges
    send_idle_pct = 37;
    stall_pct = 37;
    foreach (dir_default[i]) samples_to_send.push_back(dir_default[i]);
    wait_drain();

    set_limits(SAMPLE_MIN, SAMPLE_MAX);
    foreach (dir_wide[i]) samples_to_send.push_back(dir_wide[i]);
    wait_drain();

    // crossed limits reject everything
    set_limits(100, -100);
    foreach (dir_crossed[i]) samples_to_send.push_back(dir_crossed[i]);
    wait_drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          lo = SAMPLE_MIN;
          hi = SAMPLE_MAX;
        end
        1: begin
          lo = LOWER_RST;
          hi = UPPER_RST;
        end
        2: begin
          t = longint'($urandom_range(200000)) - 100000;
          lo = t[DW-1:0];
          t = t + longint'($urandom_range(100000));
          hi = t[DW-1:0];
        end
        3: begin
          t = longint'($urandom_range(100000, 1000));
          lo = t[DW-1:0];
          t = -t;
          hi = t[DW-1:0];
        end
        4: begin
          lo = DW'($urandom);
          hi = lo;
        end
        5: begin
          t = longint'($urandom_range(200000)) - 100000;
          lo = t[DW-1:0];
          t = t + 50;
          hi = t[DW-1:0];
        end
        6: begin
          lo = SAMPLE_MIN;
          hi = DW'(-8000000);
        end
        default: begin
          lo = DW'($urandom);
          hi = DW'($urandom);
        end
      endcase
      set_limits(lo, hi);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 61;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 61;
        end
        default: begin
          send_idle_pct = 37;
          stall_pct = 37;
        end
      endcase
      base = pick_base();
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(39) == 0) base = pick_base();
        samples_to_send.push_back(gen_reading(base));
      end
      wait_drain();
    end

    repeat (60) @(negedge clk);
    if (readings_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", readings_due.size()));
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sof_pkg.sv
rtl/sof_ctrl.sv
rtl/sof_dp.sv
rtl/sensor_outlier_filter.sv
bench/testbench.sv
